// File: hw/rtl/ljps_pkg.sv
// ----------------------------------------------------------------------------
// ljps_pkg
// Shared types and constants for the Lennard-Jones 12-6 pair energy core.
// ----------------------------------------------------------------------------
package ljps_pkg;

    localparam int DIST_W     = 24;
    localparam int EPS_W      = 28;
    localparam int SUM_W      = 48;
    localparam int RATIO_FRAC = 32;
    localparam int QUOT_W     = DIST_W + RATIO_FRAC;   // sigma * 2^32 / r
    localparam int DIV_STEPS  = QUOT_W / 2;            // two quotient bits per cycle
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int OPND_W     = 63;                    // multiplier operand, <= 2^62
    localparam int HALF_W     = 32;
    localparam int ACC_W      = 2 * OPND_W;
    localparam int MUL_LAST   = 5;                     // 4 partials + drain + finalize
    localparam int MUL_CNT_W  = 3;
    localparam int S6Q_W      = OPND_W - 16;
    localparam int SUM_EXT_W  = OPND_W + 2;
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

    localparam logic [DIST_W-1:0]        CUTOFF_RESET = DIST_W'(786432);
    localparam logic [OPND_W-1:0]        CLAMP_CAP    = OPND_W'(1) << (OPND_W - 1);
    localparam logic signed [SUM_W-1:0]  SUM_MAX      = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN      = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [DIST_W-1:0] pair_distance;
        logic [DIST_W-1:0] pair_sigma;
        logic [EPS_W-1:0]  pair_epsilon;
        logic              dispersion_excluded;
        logic              pair_frozen;
        logic              last_pair;
    } ljps_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] total_energy;
        logic                    overflowed;
    } ljps_out_t;

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_ZERO_DIST,
        KIND_EVAL
    } pair_kind_t;

    typedef struct packed {
        pair_kind_t        kind;
        logic [DIST_W-1:0] distance;
        logic [DIST_W-1:0] sigma;
        logic [EPS_W-1:0]  epsilon;
        logic              last;
    } ljps_cmd_t;

    typedef enum logic [1:0] {
        SHIFT_32,
        SHIFT_48,
        SHIFT_14
    } mul_shift_t;

    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] sigma;
        logic [DIST_W-1:0] divisor;
    } ljps_div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } ljps_div_rsp_t;

    typedef struct packed {
        logic              start;
        mul_shift_t        shift;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
    } ljps_mul_req_t;

    typedef struct packed {
        logic              done;
        logic [OPND_W-1:0] result;
    } ljps_mul_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_S2,
        B_S4,
        B_S6,
        B_S12,
        B_EPS,
        B_FINISH
    } back_state_t;

endpackage

// File: hw/rtl/ljps_front.sv
// ----------------------------------------------------------------------------
// ljps_front
// Takes pairs, applies cutoff/exclusion checks and queues classified commands.
// ----------------------------------------------------------------------------
module ljps_front import ljps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ljps_in_t          in_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DIST_W-1:0] cfg_data,
    output ljps_cmd_t         cmd,
    output logic              cmd_empty,
    input  logic              cmd_pop
);

    logic [DIST_W-1:0]    cutoff_reg, cutoff_next;
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    ljps_cmd_t            q_mem [CMD_DEPTH];
    ljps_cmd_t            cmd_in;
    logic                 counted;
    logic                 do_push;
    logic                 do_pop;

    assign cfg_ready = 1'b1;
    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign cmd_empty = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && !cmd_empty;
    assign cmd       = q_mem[rd_ptr_reg];

    assign counted = !((in_data.pair_distance > cutoff_reg) ||
                       in_data.dispersion_excluded || in_data.pair_frozen);

    always_comb
    begin
        cmd_in.distance = in_data.pair_distance;
        cmd_in.sigma    = in_data.pair_sigma;
        cmd_in.epsilon  = in_data.pair_epsilon;
        cmd_in.last     = in_data.last_pair;
        if (!counted)
        begin
            cmd_in.kind = KIND_SKIP;
        end
        else if (in_data.pair_distance == '0)
        begin
            cmd_in.kind = KIND_ZERO_DIST;
        end
        else if (in_data.pair_epsilon == '0 || in_data.pair_sigma == '0)
        begin
            cmd_in.kind = KIND_SKIP;
        end
        else
        begin
            cmd_in.kind = KIND_EVAL;
        end
    end

    always_comb
    begin
        cutoff_next = (cfg_valid && cfg_ready) ? cfg_data : cutoff_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            cutoff_reg <= cutoff_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMD_CNT_W'(CMD_DEPTH))
        else $error("command queue count out of range");

endmodule

// File: hw/rtl/ljps_div.sv
// ----------------------------------------------------------------------------
// ljps_div
// Radix-4 restoring divider: (sigma << 32) / r, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ljps_div import ljps_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  ljps_div_req_t req,
    output ljps_div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIST_W-1:0]    divisor_reg, divisor_next;
    logic [DIST_W-1:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [DIST_W:0]      t1, t2, r1, r2;
    logic                 ge1, ge2;

    assign t1  = {rem_reg, quot_reg[QUOT_W-1]};
    assign ge1 = (t1 >= {1'b0, divisor_reg});
    assign r1  = ge1 ? t1 - {1'b0, divisor_reg} : t1;
    assign t2  = {r1[DIST_W-1:0], quot_reg[QUOT_W-2]};
    assign ge2 = (t2 >= {1'b0, divisor_reg});
    assign r2  = ge2 ? t2 - {1'b0, divisor_reg} : t2;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            divisor_next = req.divisor;
            rem_next     = '0;
            quot_next    = {req.sigma, {RATIO_FRAC{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_next  = r2[DIST_W-1:0];
            quot_next = {quot_reg[QUOT_W-3:0], ge1, ge2};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// File: hw/rtl/ljps_mul.sv
// ----------------------------------------------------------------------------
// ljps_mul
// 63x63 multiply from four 32x32 partials, then round, shift and clamp.
// ----------------------------------------------------------------------------
module ljps_mul import ljps_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  ljps_mul_req_t req,
    output ljps_mul_rsp_t rsp
);

    localparam logic [ACC_W:0] ONE_EXT = (ACC_W + 1)'(1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    mul_shift_t           shift_reg, shift_next;
    logic [OPND_W-1:0]    a_reg, a_next;
    logic [OPND_W-1:0]    b_reg, b_next;
    logic [2*HALF_W-1:0]  prod_reg, prod_next;
    logic [1:0]           pos_reg, pos_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [OPND_W-1:0]    result_reg, result_next;
    logic [HALF_W-1:0]    a_sel, b_sel;

    function automatic logic [OPND_W-1:0] round_shift(input logic [ACC_W-1:0] acc,
                                                      input mul_shift_t sh);
        logic [6:0]     amt;
        logic [ACC_W:0] rnd;
        logic [ACC_W:0] q;
        case (sh)
            SHIFT_32: amt = 7'd32;
            SHIFT_48: amt = 7'd48;
            SHIFT_14: amt = 7'd14;
            default:  amt = 7'd32;
        endcase
        rnd = {1'b0, acc} + (ONE_EXT << (amt - 7'd1));
        q   = rnd >> amt;
        if (|q[ACC_W:OPND_W-1])
        begin
            return CLAMP_CAP;
        end
        return q[OPND_W-1:0];
    endfunction

    assign a_sel = cnt_reg[1] ? HALF_W'(a_reg[OPND_W-1:HALF_W]) : a_reg[HALF_W-1:0];
    assign b_sel = cnt_reg[0] ? HALF_W'(b_reg[OPND_W-1:HALF_W]) : b_reg[HALF_W-1:0];

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        prod_next   = a_sel * b_sel;
        pos_next    = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        acc_next    = acc_reg;
        result_next = result_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = req.shift;
            a_next     = req.a;
            b_next     = req.b;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg >= MUL_CNT_W'(1) && cnt_reg <= MUL_CNT_W'(4))
            begin
                acc_next = acc_reg + (ACC_W'(prod_reg) << {pos_reg, 5'b0});
            end
            if (cnt_reg == MUL_CNT_W'(MUL_LAST))
            begin
                result_next = round_shift(acc_reg, shift_reg);
                busy_next   = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        prod_reg   <= prod_next;
        pos_reg    <= pos_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

// File: hw/rtl/ljps_back.sv
// ----------------------------------------------------------------------------
// ljps_back
// Evaluates queued pairs, keeps the saturating sum and holds the result.
// ----------------------------------------------------------------------------
module ljps_back import ljps_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  ljps_cmd_t cmd,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    output logic      empty,
    input  logic      pop,
    output ljps_out_t out_data
);

    back_state_t             state_reg, state_next;
    logic [EPS_W-1:0]        eps_reg, eps_next;
    logic                    last_reg, last_next;
    logic [OPND_W-1:0]       s2_reg, s2_next;
    logic [S6Q_W-1:0]        s6q_reg, s6q_next;
    logic                    neg_reg, neg_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    ovf_reg, ovf_next;
    ljps_out_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    ljps_div_req_t           div_req;
    ljps_div_rsp_t           div_rsp;
    ljps_mul_req_t           mul_req;
    ljps_mul_rsp_t           mul_rsp;

    logic                    out_free;
    logic [OPND_W:0]         s6_round;
    logic [OPND_W-1:0]       s6q_ext;
    logic                    d_neg;
    logic [OPND_W-1:0]       d_mag;
    logic signed [SUM_EXT_W-1:0] sum_ext, mag_ext, sum_new;

    ljps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ljps_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign out_data = out_reg;

    assign s6_round = {1'b0, mul_rsp.result} + (OPND_W + 1)'(32768);
    assign s6q_ext  = OPND_W'(s6q_reg);
    assign d_neg    = (mul_rsp.result < s6q_ext);
    assign d_mag    = d_neg ? s6q_ext - mul_rsp.result : mul_rsp.result - s6q_ext;

    assign sum_ext  = SUM_EXT_W'(sum_reg);
    assign mag_ext  = signed'(SUM_EXT_W'(mul_rsp.result));
    assign sum_new  = neg_reg ? sum_ext - mag_ext : sum_ext + mag_ext;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = (cmd.kind == KIND_EVAL) ? B_DIV : B_FINISH;
                end
            end
            B_DIV:    if (div_rsp.done) state_next = B_S2;
            B_S2:     if (mul_rsp.done) state_next = B_S4;
            B_S4:     if (mul_rsp.done) state_next = B_S6;
            B_S6:     if (mul_rsp.done) state_next = B_S12;
            B_S12:    if (mul_rsp.done) state_next = B_EPS;
            B_EPS:    if (mul_rsp.done) state_next = B_FINISH;
            B_FINISH: if (!last_reg || out_free) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop         = 1'b0;
        div_req.start   = 1'b0;
        div_req.sigma   = cmd.sigma;
        div_req.divisor = cmd.distance;
        mul_req.start   = 1'b0;
        mul_req.shift   = SHIFT_32;
        mul_req.a       = mul_rsp.result;
        mul_req.b       = mul_rsp.result;
        eps_next        = eps_reg;
        last_next       = last_reg;
        s2_next         = s2_reg;
        s6q_next        = s6q_reg;
        neg_next        = neg_reg;
        sum_next        = sum_reg;
        ovf_next        = ovf_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !pop;
        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    eps_next  = cmd.epsilon;
                    last_next = cmd.last;
                    case (cmd.kind)
                        KIND_ZERO_DIST:
                        begin
                            sum_next = SUM_MAX;
                            ovf_next = 1'b1;
                        end
                        KIND_EVAL: div_req.start = 1'b1;
                        default:   ;
                    endcase
                end
            end
            B_DIV:
            begin
                mul_req.a = OPND_W'(div_rsp.quotient);
                mul_req.b = OPND_W'(div_rsp.quotient);
                mul_req.start = div_rsp.done;
            end
            B_S2:
            begin
                if (mul_rsp.done)
                begin
                    s2_next = mul_rsp.result;
                end
                mul_req.start = mul_rsp.done;
            end
            B_S4:
            begin
                mul_req.b     = s2_reg;
                mul_req.start = mul_rsp.done;
            end
            B_S6:
            begin
                if (mul_rsp.done)
                begin
                    s6q_next = s6_round[OPND_W-1:16];
                end
                mul_req.shift = SHIFT_48;
                mul_req.start = mul_rsp.done;
            end
            B_S12:
            begin
                if (mul_rsp.done)
                begin
                    neg_next = d_neg;
                end
                mul_req.shift = SHIFT_14;
                mul_req.a     = OPND_W'(eps_reg);
                mul_req.b     = d_mag;
                mul_req.start = mul_rsp.done;
            end
            B_EPS:
            begin
                if (mul_rsp.done)
                begin
                    if (sum_new > SUM_EXT_W'(SUM_MAX))
                    begin
                        sum_next = SUM_MAX;
                        ovf_next = 1'b1;
                    end
                    else if (sum_new < SUM_EXT_W'(SUM_MIN))
                    begin
                        sum_next = SUM_MIN;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_new[SUM_W-1:0];
                    end
                end
            end
            B_FINISH:
            begin
                if (last_reg && out_free)
                begin
                    out_next.total_energy = sum_reg;
                    out_next.overflowed   = ovf_reg;
                    out_valid_next        = 1'b1;
                    sum_next              = '0;
                    ovf_next              = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            last_reg      <= 1'b0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eps_reg <= eps_next;
        s2_reg  <= s2_next;
        s6q_reg <= s6q_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == B_DIV)
        else $error("divider done outside divide state");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == B_S2 || state_reg == B_S4 || state_reg == B_S6 ||
                          state_reg == B_S12 || state_reg == B_EPS))
        else $error("multiplier done outside a multiply state");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_FINISH && last_reg))
        else $error("result loaded outside finish of a last pair");

    a_zero_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && cmd_pop && cmd.kind == KIND_ZERO_DIST) |=>
            (sum_reg == SUM_MAX && ovf_reg))
        else $error("zero distance pair did not saturate the sum");

endmodule

// File: hw/rtl/lennard_jones_pair_energy_sum_core.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_energy_sum_core
// Lennard-Jones 12-6 pair energy accumulator with a saturating Q32.16 sum.
// ----------------------------------------------------------------------------
// Evaluated pair: the command is taken, the radix-4 divider runs, then five
// passes go through the shared four-partial multiplier, then finish.
// Skipped or zero-distance pair: taken, then finish. The result is registered at finish.
// A two-entry command queue lets pairs be taken while one is being evaluated.
// Reset: asynchronous, active low; clears sum, flag, queues; cutoff = 12.0 A.
// ----------------------------------------------------------------------------
module lennard_jones_pair_energy_sum_core import ljps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ljps_in_t          in_data,
    output logic              empty,
    input  logic              pop,
    output ljps_out_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DIST_W-1:0] cfg_data
);

    ljps_cmd_t cmd;
    logic      cmd_empty;
    logic      cmd_pop;

    ljps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    ljps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

endmodule
